// File: sv/wpf_pkg.sv
// Shared types, constants and helper functions of the waypoint path follower.
// No dependencies; every other file of the block imports this package.
package wpf_pkg;

    localparam int MAX_WAYPOINTS = 16;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int LEN_W         = $clog2(MAX_WAYPOINTS) + 1;
    localparam int FRAC_BITS     = 16;
    localparam int RATIO_FRAC    = 30;
    localparam int SRC_W         = 66;
    localparam int REM_W         = 37;
    localparam int Q_W           = 34;
    localparam int CNT_W         = 6;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_PLACE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_PING_PONG = 2'd1,
        CFG_PATH_LEN  = 2'd2,
        CFG_SPEED     = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        IU_SQRT = 1'b0,
        IU_DIV  = 1'b1
    } t_iu_op;

    typedef struct packed {
        logic             start;
        t_iu_op           op;
        logic [CNT_W-1:0] count;
    } t_iu_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_SUM,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_MVX,
        S_MVY,
        S_MVD,
        S_VX_GO,
        S_VX_WAIT,
        S_VY_GO,
        S_VY_WAIT,
        S_FIN
    } t_state;

    // Clamp a 34-bit signed value to the 32-bit signed range.
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Apply sign to an unsigned velocity magnitude with saturation.
    function automatic logic [31:0] vel_sat(input logic neg, input logic big,
                                            input logic [31:0] q);
        logic [31:0] r;
        if (neg) begin
            r = (big || q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
        end else begin
            r = (big || q[31]) ? 32'h7FFF_FFFF : q;
        end
        return r;
    endfunction

endpackage

// File: sv/wpf_iter_unit.sv
// Shared iterative unit: restoring square root (two bits a cycle) and
// restoring division (one bit a cycle) over one compare-subtract. Uses wpf_pkg.
module wpf_iter_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wpf_pkg::t_iu_req      i_req,
    input  logic [65:0]           i_src,
    input  logic [36:0]           i_rem,
    input  logic [33:0]           i_divisor,
    output logic                  o_done,
    output logic [33:0]           o_result
);
    import wpf_pkg::*;

    logic             r_busy;
    logic             r_done;
    t_iu_op           r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [SRC_W-1:0] r_src;
    logic [REM_W-1:0] r_rem;
    logic [Q_W-1:0]   r_q;
    logic [Q_W-1:0]   r_div;

    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
        if (r_op == IU_SQRT) begin
            shifted = {r_rem[REM_W-3:0], r_src[SRC_W-1 -: 2]};
            trial   = {1'b0, r_q, 2'b01};
        end else begin
            shifted = {r_rem[REM_W-2:0], r_src[SRC_W-1]};
            trial   = {3'b000, r_div};
        end
        ge = (shifted >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_src <= i_src;
            r_rem <= i_rem;
            r_div <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (shifted - trial) : shifted;
            r_q   <= {r_q[Q_W-2:0], ge};
            r_src <= (r_op == IU_SQRT) ? {r_src[SRC_W-3:0], 2'b00}
                                       : {r_src[SRC_W-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_q;

endmodule

// File: sv/waypoint_path_follower_core.sv
// Top level of the waypoint path follower: command sequencer, waypoint table,
// shared multiplier and position state. Uses wpf_pkg and wpf_iter_unit.
//
// One point follows a table of up to 16 waypoints in signed Q16.16. Each input
// item carries a command in tuser: write a waypoint, tick one time step, place
// the point, or do nothing; every item yields exactly one result item with the
// position, velocity, heading index, ping-pong direction and an arrival flag.
// Items are handled one at a time and the block is not ready while it works
// or while a result waits. Write, place and no-op items, and a tick on a
// disabled block or a path shorter than two waypoints, raise their result
// straight from the idle state. A moving tick runs through a shared 34x34
// multiplier and one shared iterative unit: a square root for the distance,
// then, unless the point snaps, a division for the step ratio, then up to two
// divisions for the velocities (skipped for a zero time step or a velocity
// that saturates outright). Waypoint entries never written read undefined.
module waypoint_path_follower_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data,
    // Input items.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata from bit 0: slot[3:0], coord_x[35:4], coord_y[67:36],
    // time_step[83:68], zero fill [87:84].
    input  logic [87:0]  i_s_tdata,
    // tuser: command[1:0].
    input  logic [1:0]   i_s_tuser,
    // Result items.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata from bit 0: pos_x[31:0], pos_y[63:32], vel_x[95:64],
    // vel_y[127:96], heading_index[131:128], going_forward[132],
    // arrived[133], zero fill [135:134].
    output logic [135:0] o_m_tdata
);
    import wpf_pkg::*;

    // Configuration registers.
    logic        r_enable;
    logic        r_ping_pong;
    logic [4:0]  r_path_len;
    logic [30:0] r_speed;

    // Block state.
    t_state           r_state, n_state;
    logic             r_out_valid;
    logic [31:0]      r_pos_x, r_pos_y, r_vel_x, r_vel_y;
    logic [IDX_W-1:0] r_tgt;
    logic             r_fwd;
    logic             r_arrived;

    // Captured item and work registers.
    t_cmd             r_cmd;
    logic [15:0]      r_ts;
    logic [31:0]      r_ox, r_oy;
    logic [31:0]      r_wx, r_wy;
    logic [32:0]      r_ax, r_ay;
    logic             r_nx, r_ny;
    logic [30:0]      r_step;
    logic [30:0]      r_ratio;
    logic [33:0]      r_dist;
    logic [65:0]      r_sum;
    logic [67:0]      r_prod;

    // Waypoint table.
    logic [31:0] mem_x [MAX_WAYPOINTS];
    logic [31:0] mem_y [MAX_WAYPOINTS];

    logic             accept;
    t_cmd             in_cmd;
    logic [IDX_W-1:0] in_slot;
    logic [31:0]      in_x, in_y;
    logic [15:0]      in_ts;
    logic [LEN_W-1:0] n_len;

    logic [33:0]      mul_a, mul_b;
    logic [67:0]      mul_p;

    t_iu_req          iu_req;
    logic [65:0]      iu_src;
    logic [36:0]      iu_rem;
    logic [33:0]      iu_div;
    logic             iu_done;
    logic [33:0]      iu_res;

    logic             snap;
    logic [IDX_W-1:0] snap_tgt;
    logic             snap_fwd;
    logic signed [32:0] dx, dy;
    logic signed [33:0] mv_sum;
    logic signed [32:0] vdelta;
    logic [32:0]      vmag;
    logic             vneg;
    logic             vbig;

    assign in_cmd  = t_cmd'(i_s_tuser);
    assign in_slot = i_s_tdata[3:0];
    assign in_x    = i_s_tdata[35:4];
    assign in_y    = i_s_tdata[67:36];
    assign in_ts   = i_s_tdata[83:68];

    assign o_s_tready = (r_state == S_IDLE) && !r_out_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_arrived, r_fwd, r_tgt,
                         r_vel_y, r_vel_x, r_pos_y, r_pos_x};

    // Path length saturates at the table depth.
    assign n_len = (r_path_len > 5'(MAX_WAYPOINTS)) ? LEN_W'(MAX_WAYPOINTS)
                                                    : LEN_W'(r_path_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_ping_pong <= 1'b0;
            r_path_len  <= '0;
            r_speed     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                CFG_PING_PONG: r_ping_pong <= i_cfg_data[0];
                CFG_PATH_LEN:  r_path_len  <= i_cfg_data[4:0];
                CFG_SPEED:     r_speed     <= i_cfg_data;
                default:       r_enable    <= r_enable;
            endcase
        end
    end

    // Table write on a write item, registered read of the heading entry.
    always_ff @(posedge i_clk) begin
        if (accept && in_cmd == CMD_WRITE) begin
            mem_x[in_slot] <= in_x;
            mem_y[in_slot] <= in_y;
        end
        if (r_state == S_READ) begin
            r_wx <= mem_x[r_tgt];
            r_wy <= mem_y[r_tgt];
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        unique case (r_state)
            S_READ:  begin mul_a = 34'(r_speed); mul_b = 34'(r_ts);    end
            S_SQX:   begin mul_a = 34'(r_ax);    mul_b = 34'(r_ax);    end
            S_SQY:   begin mul_a = 34'(r_ay);    mul_b = 34'(r_ay);    end
            S_MVX:   begin mul_a = 34'(r_ax);    mul_b = 34'(r_ratio); end
            S_MVY:   begin mul_a = 34'(r_ay);    mul_b = 34'(r_ratio); end
            default: begin mul_a = '0;           mul_b = '0;           end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Gaps to the waypoint, snap test and the heading after a snap.
    always_comb begin
        dx = $signed({r_wx[31], r_wx}) - $signed({r_pos_x[31], r_pos_x});
        dy = $signed({r_wy[31], r_wy}) - $signed({r_pos_y[31], r_pos_y});
        snap = (iu_res < 34'(r_step)) || (iu_res == '0);
        snap_tgt = r_tgt;
        snap_fwd = r_fwd;
        if (r_ping_pong) begin
            if (r_fwd) begin
                if (LEN_W'(r_tgt) + 1'b1 >= n_len) begin
                    snap_tgt = IDX_W'(n_len - LEN_W'(2));
                    snap_fwd = 1'b0;
                end else begin
                    snap_tgt = r_tgt + 1'b1;
                end
            end else if (r_tgt == '0) begin
                snap_tgt = IDX_W'(1);
                snap_fwd = 1'b1;
            end else begin
                snap_tgt = r_tgt - 1'b1;
            end
        end else begin
            snap_tgt = (LEN_W'(r_tgt) + 1'b1 == n_len) ? '0 : r_tgt + 1'b1;
        end
    end

    // Signed move of the current axis and the velocity operand.
    always_comb begin
        if (r_state == S_MVY) begin
            mv_sum = r_nx ? $signed({{2{r_ox[31]}}, r_ox}) - $signed({1'b0, r_prod[62:30]})
                          : $signed({{2{r_ox[31]}}, r_ox}) + $signed({1'b0, r_prod[62:30]});
        end else begin
            mv_sum = r_ny ? $signed({{2{r_oy[31]}}, r_oy}) - $signed({1'b0, r_prod[62:30]})
                          : $signed({{2{r_oy[31]}}, r_oy}) + $signed({1'b0, r_prod[62:30]});
        end
        if (r_state == S_VY_GO || r_state == S_VY_WAIT) begin
            vdelta = $signed({r_pos_y[31], r_pos_y}) - $signed({r_oy[31], r_oy});
        end else begin
            vdelta = $signed({r_pos_x[31], r_pos_x}) - $signed({r_ox[31], r_ox});
        end
        vneg = vdelta[32];
        vmag = vneg ? 33'(-vdelta) : 33'(vdelta);
        vbig = (vmag[32:16] >= {1'b0, r_ts});
    end

    // Sequencer next state and requests to the shared unit.
    always_comb begin
        n_state = r_state;
        iu_req  = '{start: 1'b0, op: IU_SQRT, count: '0};
        iu_src  = '0;
        iu_rem  = '0;
        iu_div  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_cmd == CMD_TICK && r_enable && n_len >= LEN_W'(2)) begin
                    n_state = S_READ;
                end
            end
            S_READ:      n_state = S_DIFF;
            S_DIFF:      n_state = S_SQX;
            S_SQX:       n_state = S_SQY;
            S_SQY:       n_state = S_SUM;
            S_SUM:       n_state = S_SQRT_GO;
            S_SQRT_GO: begin
                iu_req  = '{start: 1'b1, op: IU_SQRT, count: CNT_W'(33)};
                iu_src  = r_sum;
                n_state = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (iu_done) begin
                    n_state = snap ? S_VX_GO : S_RATIO_GO;
                end
            end
            S_RATIO_GO: begin
                // Quotient fits 31 bits since the step never exceeds the distance.
                iu_req  = '{start: 1'b1, op: IU_DIV, count: CNT_W'(31)};
                iu_src  = {r_step[0], 65'd0};
                iu_rem  = 37'(r_step[30:1]);
                iu_div  = r_dist;
                n_state = S_RATIO_WAIT;
            end
            S_RATIO_WAIT: if (iu_done) n_state = S_MVX;
            S_MVX:       n_state = S_MVY;
            S_MVY:       n_state = S_MVD;
            S_MVD:       n_state = S_VX_GO;
            S_VX_GO, S_VY_GO: begin
                if (r_ts == '0) begin
                    n_state = S_FIN;
                end else if (vbig) begin
                    n_state = (r_state == S_VX_GO) ? S_VY_GO : S_FIN;
                end else begin
                    iu_req  = '{start: 1'b1, op: IU_DIV, count: CNT_W'(32)};
                    iu_src  = {vmag[15:0], 50'd0};
                    iu_rem  = 37'(vmag[32:16]);
                    iu_div  = 34'(r_ts);
                    n_state = (r_state == S_VX_GO) ? S_VX_WAIT : S_VY_WAIT;
                end
            end
            S_VX_WAIT:   if (iu_done) n_state = S_VY_GO;
            S_VY_WAIT:   if (iu_done) n_state = S_FIN;
            S_FIN:       n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Block state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_tgt       <= '0;
            r_fwd       <= 1'b1;
            r_arrived   <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_arrived <= 1'b0;
                        unique case (in_cmd)
                            CMD_TICK: begin
                                if (!r_enable || n_len < LEN_W'(2)) begin
                                    r_vel_x     <= '0;
                                    r_vel_y     <= '0;
                                    r_out_valid <= 1'b1;
                                end else if (LEN_W'(r_tgt) >= n_len) begin
                                    r_tgt <= '0;
                                end
                            end
                            CMD_PLACE: begin
                                r_pos_x     <= in_x;
                                r_pos_y     <= in_y;
                                r_tgt       <= in_slot;
                                r_fwd       <= 1'b1;
                                r_vel_x     <= '0;
                                r_vel_y     <= '0;
                                r_out_valid <= 1'b1;
                            end
                            CMD_WRITE, CMD_NOP: r_out_valid <= 1'b1;
                            default:            r_out_valid <= 1'b1;
                        endcase
                    end
                end
                S_SQRT_WAIT: begin
                    if (iu_done && snap) begin
                        r_pos_x   <= r_wx;
                        r_pos_y   <= r_wy;
                        r_tgt     <= snap_tgt;
                        r_fwd     <= snap_fwd;
                        r_arrived <= 1'b1;
                    end
                end
                S_MVY: r_pos_x <= sat32(mv_sum);
                S_MVD: r_pos_y <= sat32(mv_sum);
                S_VX_GO: begin
                    if (r_ts != '0 && vbig) r_vel_x <= vel_sat(vneg, 1'b1, '0);
                end
                S_VY_GO: begin
                    if (r_ts != '0 && vbig) r_vel_y <= vel_sat(vneg, 1'b1, '0);
                end
                S_VX_WAIT: if (iu_done) r_vel_x <= vel_sat(vneg, 1'b0, iu_res[31:0]);
                S_VY_WAIT: if (iu_done) r_vel_y <= vel_sat(vneg, 1'b0, iu_res[31:0]);
                S_FIN:     r_out_valid <= 1'b1;
                default:   r_arrived <= r_arrived;
            endcase
        end
    end

    // Work registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= in_cmd;
            r_ts  <= in_ts;
        end
        if (r_state == S_READ || r_state == S_SQX || r_state == S_SQY ||
            r_state == S_MVX || r_state == S_MVY) begin
            r_prod <= mul_p;
        end
        if (r_state == S_DIFF) begin
            r_ox   <= r_pos_x;
            r_oy   <= r_pos_y;
            r_nx   <= dx[32];
            r_ny   <= dy[32];
            r_ax   <= dx[32] ? 33'(-dx) : 33'(dx);
            r_ay   <= dy[32] ? 33'(-dy) : 33'(dy);
            r_step <= r_prod[46:16];
        end
        if (r_state == S_SQY) r_sum <= r_prod[65:0];
        if (r_state == S_SUM) r_sum <= r_sum + r_prod[65:0];
        if (r_state == S_SQRT_WAIT && iu_done) r_dist <= iu_res;
        if (r_state == S_RATIO_WAIT && iu_done) r_ratio <= iu_res[30:0];
    end

    wpf_iter_unit u_iter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (iu_req),
        .i_src     (iu_src),
        .i_rem     (iu_rem),
        .i_divisor (iu_div),
        .o_done    (iu_done),
        .o_result  (iu_res)
    );

    // A pending result only ever waits while the sequencer is idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_IDLE)
        else $error("result pending outside idle");

    // The shared unit finishes only while the sequencer waits on it.
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iu_done |-> (r_state == S_SQRT_WAIT || r_state == S_RATIO_WAIT ||
                     r_state == S_VX_WAIT || r_state == S_VY_WAIT))
        else $error("shared unit done in wrong state");

    // Arrival is flagged only on a tick item.
    a_arrive_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_arrived) |-> r_cmd == CMD_TICK)
        else $error("arrival on a non-tick item");

endmodule
